// ===== hdl/smcd_pkg.sv =====
// Shared types and constants for the serial motor command decoder.
// Holds the item and result structs, command byte codes and sequence phase codes.
// No dependencies.
package smcd_pkg;

   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 32;
   localparam int unsigned SIDX_W     = 5;

   localparam logic MODE_COMMAND = 1'b0;
   localparam logic MODE_SENSOR  = 1'b1;

   localparam logic [7:0] CMD_FORWARD     = 8'h61;
   localparam logic [7:0] CMD_BACKWARD    = 8'h62;
   localparam logic [7:0] CMD_LEFT        = 8'h63;
   localparam logic [7:0] CMD_RIGHT       = 8'h64;
   localparam logic [7:0] CMD_STOP        = 8'h65;
   localparam logic [7:0] CMD_BUZZ_ON     = 8'h66;
   localparam logic [7:0] CMD_BUZZ_OFF    = 8'h67;
   localparam logic [7:0] CMD_REPLY_FIRST = 8'h68;
   localparam logic [7:0] CMD_REPLY_LAST  = 8'h78;
   localparam logic [7:0] CMD_SPEED_L     = 8'h79;
   localparam logic [7:0] CMD_SPEED_L2    = 8'h7A;
   localparam logic [7:0] CMD_SPEED_R     = 8'h41;
   localparam logic [7:0] CMD_SPEED_R2    = 8'h42;

   localparam logic [3:0] DIR_FORWARD  = 4'h6;
   localparam logic [3:0] DIR_BACKWARD = 4'h9;
   localparam logic [3:0] DIR_LEFT     = 4'h5;
   localparam logic [3:0] DIR_RIGHT    = 4'hA;
   localparam logic [3:0] DIR_STOP     = 4'h0;

   localparam logic [7:0] DUTY_RESET = 8'hFF;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_LEFT   = 3'd1;
   localparam logic [2:0] PH_LEFT2  = 3'd2;
   localparam logic [2:0] PH_RIGHT  = 3'd3;
   localparam logic [2:0] PH_RIGHT2 = 3'd4;

   typedef struct packed {
      logic              mode;
      logic [7:0]        rx_byte;
      logic [SIDX_W-1:0] sensor_index;
      logic [7:0]        sensor_value;
   } item_type;

   typedef struct packed {
      logic [3:0] direction;
      logic       buzzer;
      logic [7:0] left_duty;
      logic [7:0] right_duty;
      logic       reply_valid;
      logic [7:0] reply_byte;
   } result_type;

endpackage

// ===== hdl/smcd_decode.sv =====
// Command decoder core: sequence phase, motor and buzzer state, sensor store.
// Computes the result of one item and commits the state when the item advances.
// Depends on smcd_pkg.
module smcd_decode
   import smcd_pkg::*;
#(
   parameter int unsigned SENSOR_COUNT = 17
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   output result_type result
);

   localparam int unsigned IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
   localparam logic [SIDX_W-1:0] COUNT_LIM = SIDX_W'(SENSOR_COUNT);

   logic [2:0] phase_ff, phase_in;
   logic [7:0] pending_left_ff, pending_left_in;
   logic [7:0] pending_right_ff, pending_right_in;
   logic [7:0] left_pwm_ff, left_pwm_in;
   logic [7:0] right_pwm_ff, right_pwm_in;
   logic [3:0] dir_ff, dir_in;
   logic       buzz_ff, buzz_in;
   logic [7:0] store_ff [SENSOR_COUNT];

   logic              store_wr;
   logic              reply_valid;
   logic [7:0]        reply_byte;
   logic [SIDX_W-1:0] reply_idx;
   logic [7:0]        rx;

   assign rx = item.rx_byte;

   always_comb begin
      phase_in         = phase_ff;
      pending_left_in  = pending_left_ff;
      pending_right_in = pending_right_ff;
      left_pwm_in      = left_pwm_ff;
      right_pwm_in     = right_pwm_ff;
      dir_in           = dir_ff;
      buzz_in          = buzz_ff;
      store_wr         = 1'b0;
      reply_valid      = 1'b0;
      reply_byte       = 8'h00;
      reply_idx        = SIDX_W'(rx - CMD_REPLY_FIRST);
      if (item.mode == MODE_SENSOR) begin
         store_wr = (item.sensor_index < COUNT_LIM);
      end else begin
         phase_in = PH_IDLE;
         case (phase_ff)
            PH_LEFT: begin
               pending_left_in = rx;
            end
            PH_LEFT2: begin
               pending_left_in = {rx[6:0], 1'b0};
            end
            PH_RIGHT: begin
               pending_right_in = rx;
               left_pwm_in      = pending_left_ff;
               right_pwm_in     = rx;
            end
            PH_RIGHT2: begin
               pending_right_in = {rx[6:0], 1'b0};
               left_pwm_in      = pending_left_ff;
               right_pwm_in     = {rx[6:0], 1'b0};
            end
            default: begin
               case (rx)
                  CMD_FORWARD:  dir_in   = DIR_FORWARD;
                  CMD_BACKWARD: dir_in   = DIR_BACKWARD;
                  CMD_LEFT:     dir_in   = DIR_LEFT;
                  CMD_RIGHT:    dir_in   = DIR_RIGHT;
                  CMD_STOP:     dir_in   = DIR_STOP;
                  CMD_BUZZ_ON:  buzz_in  = 1'b1;
                  CMD_BUZZ_OFF: buzz_in  = 1'b0;
                  CMD_SPEED_L:  phase_in = PH_LEFT;
                  CMD_SPEED_L2: phase_in = PH_LEFT2;
                  CMD_SPEED_R:  phase_in = PH_RIGHT;
                  CMD_SPEED_R2: phase_in = PH_RIGHT2;
                  default: begin
                     if (rx inside {[CMD_REPLY_FIRST:CMD_REPLY_LAST]} &&
                         reply_idx < COUNT_LIM) begin
                        reply_valid = 1'b1;
                        reply_byte  = store_ff[reply_idx[IDX_W-1:0]];
                     end
                  end
               endcase
            end
         endcase
      end
   end

   always_comb begin
      result.direction   = dir_in;
      result.buzzer      = buzz_in;
      result.left_duty   = left_pwm_in;
      result.right_duty  = right_pwm_in;
      result.reply_valid = reply_valid;
      result.reply_byte  = reply_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         pending_left_ff  <= 8'h00;
         pending_right_ff <= 8'h00;
         left_pwm_ff      <= DUTY_RESET;
         right_pwm_ff     <= DUTY_RESET;
         dir_ff           <= DIR_STOP;
         buzz_ff          <= 1'b0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         pending_left_ff  <= pending_left_in;
         pending_right_ff <= pending_right_in;
         left_pwm_ff      <= left_pwm_in;
         right_pwm_ff     <= right_pwm_in;
         dir_ff           <= dir_in;
         buzz_ff          <= buzz_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (reset) begin
            store_ff[i] <= 8'h00;
         end else if (advance && store_wr &&
                      item.sensor_index[IDX_W-1:0] == IDX_W'(i)) begin
            store_ff[i] <= item.sensor_value;
         end
      end
   end

endmodule

// ===== hdl/serial_motor_command_decoder_unit.sv =====
// Top level of the serial motor command decoder: input and result registers
// around the decoder core. Depends on smcd_pkg and smcd_decode.
//
// Usage: each word on the req channel is either a received serial byte
// (tuser low) or a sensor store update (tuser high). Every accepted word
// produces exactly one word on the rsp channel with the current wheel
// direction, buzzer, applied duties and an optional sensor reply byte;
// rsp_tuser marks that the reply byte is valid.
// An accepted req word is loaded into the input register; when the result
// register is free or being taken, the decoder's result is loaded into the
// result register, which drives rsp_tvalid.
// One word per cycle is accepted while the receiver takes each result; the
// decoder state is committed in the same cycle the result register is loaded,
// so consecutive words see each other's effects in order.
// When the receiver stalls, the result register holds its word and the input
// register fills; req_tready then drops until the result is taken.
// Reset empties both registers, returns the decoder to idle, sets both duties
// to 255 and clears the sensor store.
module serial_motor_command_decoder_unit
   import smcd_pkg::*;
#(
   parameter int unsigned SENSOR_COUNT = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // rx_byte[7:0], sensor_index[12:8], sensor_value[20:13], zero[23:21]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // direction[3:0], buzzer[4], left_duty[12:5], right_duty[20:13],
   // reply_byte[28:21], zero[31:29]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // reply_valid[0]
   output logic                  rsp_tuser
);

   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type result;
   logic       advance;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.mode         <= req_tuser;
         in_item_ff.rx_byte      <= req_tdata[7:0];
         in_item_ff.sensor_index <= req_tdata[12:8];
         in_item_ff.sensor_value <= req_tdata[20:13];
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   smcd_decode #(
      .SENSOR_COUNT(SENSOR_COUNT)
   ) u_decode (
      .clock  (clock),
      .reset  (reset),
      .advance(advance),
      .item   (in_item_ff),
      .result (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.reply_valid;
   assign rsp_tdata  = {3'b000, rsp_ff.reply_byte, rsp_ff.right_duty,
                        rsp_ff.left_duty, rsp_ff.buzzer, rsp_ff.direction};

endmodule

// ===== hdl/smcd_checker.sv =====
// Port-level checker for serial_motor_command_decoder_unit, with its bind.
// Depends on smcd_pkg.
module smcd_checker
   import smcd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result channel is valid right after reset.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled result word changed.");

   a_no_reply_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[28:21] == 8'h00)
      else $error("Reply byte is nonzero without a reply.");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("Input stalled while the result side is empty.");

endmodule

bind serial_motor_command_decoder_unit smcd_checker u_smcd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);
